FILE: rtl/core/segisect_pkg.sv
// Shared types and constants for the segment intersection classifier.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package segisect_pkg;

    // Result codes
    localparam logic [1:0] HIT_NONE  = 2'd0;
    localparam logic [1:0] HIT_POINT = 2'd1;
    localparam logic [1:0] HIT_MANY  = 2'd2;

    // Product-pair terms: each is p0 -/+ p1 of two products
    localparam int NUM_TERMS = 12;
    localparam int T_C1  = 0;   // cross dirA x (b_end - a_start)
    localparam int T_C2  = 1;   // cross dirA x (b_start - a_start)
    localparam int T_C3  = 2;   // cross dirB x (a_end - b_start)
    localparam int T_C4  = 3;   // cross dirB x (a_start - b_start)
    localparam int T_DJ1 = 4;   // disjoint dot tests
    localparam int T_DJ2 = 5;
    localparam int T_DJ3 = 6;
    localparam int T_DJ4 = 7;
    localparam int T_EP1 = 8;   // shared-endpoint dot tests
    localparam int T_EP2 = 9;
    localparam int T_EP3 = 10;
    localparam int T_EP4 = 11;

    // Bit set: term is a difference (cross), clear: sum (dot)
    localparam logic [NUM_TERMS-1:0] TERM_SUB = 12'h00F;

    typedef struct packed {
        logic pos;
        logic neg;
    } sgn_t;

    typedef struct packed {
        logic a1b1;
        logic a1b2;
        logic a2b1;
        logic a2b2;
    } eq_flags_t;

endpackage

FILE: rtl/core/segisect_if.sv
// Valid/ready channel interfaces: segment pair words in, hit kind words out.
// Depends on nothing.
`timescale 1ns / 1ps

interface segisect_pair_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] a_start_x;
    logic signed [COORD_BITS-1:0] a_start_y;
    logic signed [COORD_BITS-1:0] a_end_x;
    logic signed [COORD_BITS-1:0] a_end_y;
    logic signed [COORD_BITS-1:0] b_start_x;
    logic signed [COORD_BITS-1:0] b_start_y;
    logic signed [COORD_BITS-1:0] b_end_x;
    logic signed [COORD_BITS-1:0] b_end_y;

    modport source (
        output valid, a_start_x, a_start_y, a_end_x, a_end_y,
               b_start_x, b_start_y, b_end_x, b_end_y,
        input  ready
    );
    modport sink (
        input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
               b_start_x, b_start_y, b_end_x, b_end_y,
        output ready
    );
endinterface

interface segisect_hit_if;
    logic       valid;
    logic       ready;
    logic [1:0] hit_kind;

    modport source (output valid, hit_kind, input ready);
    modport sink   (input valid, hit_kind, output ready);
endinterface

FILE: rtl/core/segment_intersection_classify_core.sv
// Segment intersection classifier, top level. Each accepted pair word passes the diff, mult,
// sign and class registers on its way to its hit word. Throughput: one pair word per cycle while
// hits.ready is high; every stage holds its word under backpressure, and bubbles close up behind a stall.
// Reset: rst_n asynchronous, active low; clears stage valid bits only.
// Depends on segisect_pkg, segisect_if and the four stage modules.
`timescale 1ns / 1ps

// Pipeline:
//   diff  - 10 difference vectors (COORD_BITS+1 bits) routed to 12 terms,
//           plus the four endpoint-equality flags
//   mult  - 24 signed multipliers, (COORD_BITS+1) x (COORD_BITS+1)
//   sign  - each term is p0 - p1 (cross) or p0 + p1 (dot), exact width,
//           reduced to a pos/neg sign pair
//   class - collinear / disjoint / touch decision into the output register
// Each stage is ready when empty or when the stage after it is ready, so the
// input side keeps taking words into empty stages while a finished word waits
// at the output, and stalls once all four stages hold a word.
module segment_intersection_classify_core #(
    parameter int COORD_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    segisect_pair_if.sink          pairs,
    segisect_hit_if.source         hits
);
    localparam int D = COORD_BITS + 1;
    localparam int P = 2 * D;

    // diff -> mult
    logic                    s1_valid, s1_ready;
    logic signed [D-1:0]     s1_opa0 [segisect_pkg::NUM_TERMS];
    logic signed [D-1:0]     s1_opb0 [segisect_pkg::NUM_TERMS];
    logic signed [D-1:0]     s1_opa1 [segisect_pkg::NUM_TERMS];
    logic signed [D-1:0]     s1_opb1 [segisect_pkg::NUM_TERMS];
    segisect_pkg::eq_flags_t s1_eq;

    // mult -> sign
    logic                    s2_valid, s2_ready;
    logic signed [P-1:0]     s2_prod0 [segisect_pkg::NUM_TERMS];
    logic signed [P-1:0]     s2_prod1 [segisect_pkg::NUM_TERMS];
    segisect_pkg::eq_flags_t s2_eq;

    // sign -> class
    logic                    s3_valid, s3_ready;
    segisect_pkg::sgn_t      s3_sgn [segisect_pkg::NUM_TERMS];
    segisect_pkg::eq_flags_t s3_eq;

    segisect_diff #(.COORD_BITS(COORD_BITS)) u_diff (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pairs.valid),
        .in_ready  (pairs.ready),
        .ax1       (pairs.a_start_x),
        .ay1       (pairs.a_start_y),
        .ax2       (pairs.a_end_x),
        .ay2       (pairs.a_end_y),
        .bx1       (pairs.b_start_x),
        .by1       (pairs.b_start_y),
        .bx2       (pairs.b_end_x),
        .by2       (pairs.b_end_y),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .opa0      (s1_opa0),
        .opb0      (s1_opb0),
        .opa1      (s1_opa1),
        .opb1      (s1_opb1),
        .eq        (s1_eq)
    );

    segisect_mult #(.COORD_BITS(COORD_BITS)) u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .opa0      (s1_opa0),
        .opb0      (s1_opb0),
        .opa1      (s1_opa1),
        .opb1      (s1_opb1),
        .in_eq     (s1_eq),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .prod0     (s2_prod0),
        .prod1     (s2_prod1),
        .out_eq    (s2_eq)
    );

    segisect_sign #(.COORD_BITS(COORD_BITS)) u_sign (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .prod0     (s2_prod0),
        .prod1     (s2_prod1),
        .in_eq     (s2_eq),
        .out_valid (s3_valid),
        .out_ready (s3_ready),
        .sgn       (s3_sgn),
        .out_eq    (s3_eq)
    );

    segisect_class u_class (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid),
        .in_ready  (s3_ready),
        .sgn       (s3_sgn),
        .eq        (s3_eq),
        .out_valid (hits.valid),
        .out_ready (hits.ready),
        .hit_kind  (hits.hit_kind)
    );

endmodule

FILE: rtl/core/segisect_diff.sv
// Stage 1: coordinate differences, multiplier operand routing, endpoint equality.
// Depends on segisect_pkg.
`timescale 1ns / 1ps

module segisect_diff #(
    parameter int COORD_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [COORD_BITS-1:0]        ax1,
    input  logic signed [COORD_BITS-1:0]        ay1,
    input  logic signed [COORD_BITS-1:0]        ax2,
    input  logic signed [COORD_BITS-1:0]        ay2,
    input  logic signed [COORD_BITS-1:0]        bx1,
    input  logic signed [COORD_BITS-1:0]        by1,
    input  logic signed [COORD_BITS-1:0]        bx2,
    input  logic signed [COORD_BITS-1:0]        by2,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [COORD_BITS:0]          opa0 [segisect_pkg::NUM_TERMS],
    output logic signed [COORD_BITS:0]          opb0 [segisect_pkg::NUM_TERMS],
    output logic signed [COORD_BITS:0]          opa1 [segisect_pkg::NUM_TERMS],
    output logic signed [COORD_BITS:0]          opb1 [segisect_pkg::NUM_TERMS],
    output segisect_pkg::eq_flags_t             eq
);
    localparam int D = COORD_BITS + 1;

    logic signed [D-1:0] dax, day, dbx, dby;
    logic signed [D-1:0] b2a1x, b2a1y, b1a1x, b1a1y;
    logic signed [D-1:0] a2b1x, a2b1y, a1b1x, a1b1y;
    logic signed [D-1:0] b2a2x, b2a2y, b1a2x, b1a2y;
    logic signed [D-1:0] a1b2x, a1b2y, a2b2x, a2b2y;

    logic signed [D-1:0] opa0_next [segisect_pkg::NUM_TERMS];
    logic signed [D-1:0] opb0_next [segisect_pkg::NUM_TERMS];
    logic signed [D-1:0] opa1_next [segisect_pkg::NUM_TERMS];
    logic signed [D-1:0] opb1_next [segisect_pkg::NUM_TERMS];
    logic signed [D-1:0] opa0_reg  [segisect_pkg::NUM_TERMS];
    logic signed [D-1:0] opb0_reg  [segisect_pkg::NUM_TERMS];
    logic signed [D-1:0] opa1_reg  [segisect_pkg::NUM_TERMS];
    logic signed [D-1:0] opb1_reg  [segisect_pkg::NUM_TERMS];
    segisect_pkg::eq_flags_t eq_next, eq_reg;
    logic                    valid_reg;

    function automatic logic signed [COORD_BITS:0] sub_ext(
        input logic signed [COORD_BITS-1:0] p,
        input logic signed [COORD_BITS-1:0] q
    );
        return $signed({p[COORD_BITS-1], p}) - $signed({q[COORD_BITS-1], q});
    endfunction

    always_comb
    begin
        dax   = sub_ext(ax2, ax1);  day   = sub_ext(ay2, ay1);
        dbx   = sub_ext(bx2, bx1);  dby   = sub_ext(by2, by1);
        b2a1x = sub_ext(bx2, ax1);  b2a1y = sub_ext(by2, ay1);
        b1a1x = sub_ext(bx1, ax1);  b1a1y = sub_ext(by1, ay1);
        a2b1x = sub_ext(ax2, bx1);  a2b1y = sub_ext(ay2, by1);
        a1b1x = sub_ext(ax1, bx1);  a1b1y = sub_ext(ay1, by1);
        b2a2x = sub_ext(bx2, ax2);  b2a2y = sub_ext(by2, ay2);
        b1a2x = sub_ext(bx1, ax2);  b1a2y = sub_ext(by1, ay2);
        a1b2x = sub_ext(ax1, bx2);  a1b2y = sub_ext(ay1, by2);
        a2b2x = sub_ext(ax2, bx2);  a2b2y = sub_ext(ay2, by2);

        // cross u x v = ux*vy - uy*vx
        opa0_next[segisect_pkg::T_C1] = dax;   opb0_next[segisect_pkg::T_C1] = b2a1y;
        opa1_next[segisect_pkg::T_C1] = day;   opb1_next[segisect_pkg::T_C1] = b2a1x;
        opa0_next[segisect_pkg::T_C2] = dax;   opb0_next[segisect_pkg::T_C2] = b1a1y;
        opa1_next[segisect_pkg::T_C2] = day;   opb1_next[segisect_pkg::T_C2] = b1a1x;
        opa0_next[segisect_pkg::T_C3] = dbx;   opb0_next[segisect_pkg::T_C3] = a2b1y;
        opa1_next[segisect_pkg::T_C3] = dby;   opb1_next[segisect_pkg::T_C3] = a2b1x;
        opa0_next[segisect_pkg::T_C4] = dbx;   opb0_next[segisect_pkg::T_C4] = a1b1y;
        opa1_next[segisect_pkg::T_C4] = dby;   opb1_next[segisect_pkg::T_C4] = a1b1x;

        // dot u . v = ux*vx + uy*vy
        opa0_next[segisect_pkg::T_DJ1] = b2a1x; opb0_next[segisect_pkg::T_DJ1] = b1a1x;
        opa1_next[segisect_pkg::T_DJ1] = b2a1y; opb1_next[segisect_pkg::T_DJ1] = b1a1y;
        opa0_next[segisect_pkg::T_DJ2] = b2a2x; opb0_next[segisect_pkg::T_DJ2] = b1a2x;
        opa1_next[segisect_pkg::T_DJ2] = b2a2y; opb1_next[segisect_pkg::T_DJ2] = b1a2y;
        opa0_next[segisect_pkg::T_DJ3] = a1b1x; opb0_next[segisect_pkg::T_DJ3] = a2b1x;
        opa1_next[segisect_pkg::T_DJ3] = a1b1y; opb1_next[segisect_pkg::T_DJ3] = a2b1y;
        opa0_next[segisect_pkg::T_DJ4] = a1b2x; opb0_next[segisect_pkg::T_DJ4] = a2b2x;
        opa1_next[segisect_pkg::T_DJ4] = a1b2y; opb1_next[segisect_pkg::T_DJ4] = a2b2y;

        // endpoint tests along dirA; the a_end cases take the sign negated later
        opa0_next[segisect_pkg::T_EP1] = dax;  opb0_next[segisect_pkg::T_EP1] = b2a1x;
        opa1_next[segisect_pkg::T_EP1] = day;  opb1_next[segisect_pkg::T_EP1] = b2a1y;
        opa0_next[segisect_pkg::T_EP2] = dax;  opb0_next[segisect_pkg::T_EP2] = b1a1x;
        opa1_next[segisect_pkg::T_EP2] = day;  opb1_next[segisect_pkg::T_EP2] = b1a1y;
        opa0_next[segisect_pkg::T_EP3] = dax;  opb0_next[segisect_pkg::T_EP3] = b2a2x;
        opa1_next[segisect_pkg::T_EP3] = day;  opb1_next[segisect_pkg::T_EP3] = b2a2y;
        opa0_next[segisect_pkg::T_EP4] = dax;  opb0_next[segisect_pkg::T_EP4] = b1a2x;
        opa1_next[segisect_pkg::T_EP4] = day;  opb1_next[segisect_pkg::T_EP4] = b1a2y;

        eq_next.a1b1 = (ax1 == bx1) && (ay1 == by1);
        eq_next.a1b2 = (ax1 == bx2) && (ay1 == by2);
        eq_next.a2b1 = (ax2 == bx1) && (ay2 == by1);
        eq_next.a2b2 = (ax2 == bx2) && (ay2 == by2);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            opa0_reg <= opa0_next;
            opb0_reg <= opb0_next;
            opa1_reg <= opa1_next;
            opb1_reg <= opb1_next;
            eq_reg   <= eq_next;
        end
    end

    assign out_valid = valid_reg;
    assign opa0      = opa0_reg;
    assign opb0      = opb0_reg;
    assign opa1      = opa1_reg;
    assign opb1      = opb1_reg;
    assign eq        = eq_reg;

endmodule

FILE: rtl/core/segisect_mult.sv
// Stage 2: 24 signed multipliers, two per term, registered.
// Depends on segisect_pkg.
`timescale 1ns / 1ps

module segisect_mult #(
    parameter int COORD_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [COORD_BITS:0]          opa0 [segisect_pkg::NUM_TERMS],
    input  logic signed [COORD_BITS:0]          opb0 [segisect_pkg::NUM_TERMS],
    input  logic signed [COORD_BITS:0]          opa1 [segisect_pkg::NUM_TERMS],
    input  logic signed [COORD_BITS:0]          opb1 [segisect_pkg::NUM_TERMS],
    input  segisect_pkg::eq_flags_t             in_eq,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [2*COORD_BITS+1:0]      prod0 [segisect_pkg::NUM_TERMS],
    output logic signed [2*COORD_BITS+1:0]      prod1 [segisect_pkg::NUM_TERMS],
    output segisect_pkg::eq_flags_t             out_eq
);
    localparam int P = 2 * COORD_BITS + 2;

    logic signed [P-1:0]     prod0_reg [segisect_pkg::NUM_TERMS];
    logic signed [P-1:0]     prod1_reg [segisect_pkg::NUM_TERMS];
    segisect_pkg::eq_flags_t eq_reg;
    logic                    valid_reg;

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            for (int k = 0; k < segisect_pkg::NUM_TERMS; k++)
            begin
                prod0_reg[k] <= P'(opa0[k]) * P'(opb0[k]);
                prod1_reg[k] <= P'(opa1[k]) * P'(opb1[k]);
            end
            eq_reg <= in_eq;
        end
    end

    assign out_valid = valid_reg;
    assign prod0     = prod0_reg;
    assign prod1     = prod1_reg;
    assign out_eq    = eq_reg;

endmodule

FILE: rtl/core/segisect_sign.sv
// Stage 3: combine each product pair and keep only the sign of the result.
// Depends on segisect_pkg.
`timescale 1ns / 1ps

module segisect_sign #(
    parameter int COORD_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [2*COORD_BITS+1:0]      prod0 [segisect_pkg::NUM_TERMS],
    input  logic signed [2*COORD_BITS+1:0]      prod1 [segisect_pkg::NUM_TERMS],
    input  segisect_pkg::eq_flags_t             in_eq,
    output logic                                out_valid,
    input  logic                                out_ready,
    output segisect_pkg::sgn_t                  sgn [segisect_pkg::NUM_TERMS],
    output segisect_pkg::eq_flags_t             out_eq
);
    localparam int P = 2 * COORD_BITS + 2;
    localparam int S = P + 1;

    logic signed [S-1:0]     sum  [segisect_pkg::NUM_TERMS];
    segisect_pkg::sgn_t      sgn_next [segisect_pkg::NUM_TERMS];
    segisect_pkg::sgn_t      sgn_reg  [segisect_pkg::NUM_TERMS];
    segisect_pkg::eq_flags_t eq_reg;
    logic                    valid_reg;

    always_comb
    begin
        for (int k = 0; k < segisect_pkg::NUM_TERMS; k++)
        begin
            if (segisect_pkg::TERM_SUB[k])
                sum[k] = $signed({prod0[k][P-1], prod0[k]})
                       - $signed({prod1[k][P-1], prod1[k]});
            else
                sum[k] = $signed({prod0[k][P-1], prod0[k]})
                       + $signed({prod1[k][P-1], prod1[k]});
            sgn_next[k].neg = sum[k][S-1];
            sgn_next[k].pos = !sum[k][S-1] && (|sum[k]);
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            sgn_reg <= sgn_next;
            eq_reg  <= in_eq;
        end
    end

    assign out_valid = valid_reg;
    assign sgn       = sgn_reg;
    assign out_eq    = eq_reg;

endmodule

FILE: rtl/core/segisect_class.sv
// Stage 4: decision logic from term signs and endpoint equality; output register.
// Depends on segisect_pkg.
`timescale 1ns / 1ps

module segisect_class (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  segisect_pkg::sgn_t      sgn [segisect_pkg::NUM_TERMS],
    input  segisect_pkg::eq_flags_t eq,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [1:0]              hit_kind
);
    logic       collinear, disjoint, touch, c12_le0, c34_le0;
    logic [1:0] kind_next, kind_reg;
    logic       valid_reg;

    function automatic logic is_zero(input segisect_pkg::sgn_t s);
        return !s.pos && !s.neg;
    endfunction

    function automatic logic prod_le0(input segisect_pkg::sgn_t p, input segisect_pkg::sgn_t q);
        return !((p.pos && q.pos) || (p.neg && q.neg));
    endfunction

    always_comb
    begin
        collinear = is_zero(sgn[segisect_pkg::T_C1]) && is_zero(sgn[segisect_pkg::T_C2]);
        disjoint  = sgn[segisect_pkg::T_DJ1].pos && sgn[segisect_pkg::T_DJ2].pos
                 && sgn[segisect_pkg::T_DJ3].pos && sgn[segisect_pkg::T_DJ4].pos;
        // shared endpoint with the segments running apart; a_end tests use -dirA
        touch     = (eq.a1b1 && !sgn[segisect_pkg::T_EP1].pos)
                 || (eq.a1b2 && !sgn[segisect_pkg::T_EP2].pos)
                 || (eq.a2b1 && !sgn[segisect_pkg::T_EP3].neg)
                 || (eq.a2b2 && !sgn[segisect_pkg::T_EP4].neg);
        c12_le0   = prod_le0(sgn[segisect_pkg::T_C1], sgn[segisect_pkg::T_C2]);
        c34_le0   = prod_le0(sgn[segisect_pkg::T_C3], sgn[segisect_pkg::T_C4]);

        if (collinear)
        begin
            if (disjoint)
                kind_next = segisect_pkg::HIT_NONE;
            else if (touch)
                kind_next = segisect_pkg::HIT_POINT;
            else
                kind_next = segisect_pkg::HIT_MANY;
        end
        else if (c12_le0 && c34_le0)
            kind_next = segisect_pkg::HIT_POINT;
        else
            kind_next = segisect_pkg::HIT_NONE;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            kind_reg <= kind_next;
    end

    assign out_valid = valid_reg;
    assign hit_kind  = kind_reg;

endmodule

FILE: rtl/core/segisect_chk.sv
// Port-level checker for the segment intersection classifier, bound to the top.
// Depends on segment_intersection_classify_core and segisect_pkg.
`timescale 1ns / 1ps

module segisect_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] hit_kind
);
    // held word at the output stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit_kind))
        else $error("output word dropped or changed while stalled");

    // only the three result codes appear
    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hit_kind == segisect_pkg::HIT_NONE)
                   || (hit_kind == segisect_pkg::HIT_POINT)
                   || (hit_kind == segisect_pkg::HIT_MANY))
        else $error("illegal hit_kind code");

    // input backpressure only comes from a full pipe stalled at the output
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

    // with the output open, an accepted word shows up once it has passed the diff, mult, sign and class registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
        else $error("result word missing after pipeline latency");

endmodule

bind segment_intersection_classify_core segisect_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pairs.valid),
    .in_ready  (pairs.ready),
    .out_valid (hits.valid),
    .out_ready (hits.ready),
    .hit_kind  (hits.hit_kind)
);
